>>> src/grd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grd_pkg
// Shared types and constants of the graph reachability block.
// ----------------------------------------------------------------------------
package grd_pkg;

  // Fixed field widths
  localparam int VTX_W = 4;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_ADD_DIR   = 2'd0,
    OP_ADD_UNDIR = 2'd1,
    OP_QUERY     = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_WALK = 2'd2,
    ST_EMIT = 2'd3
  } st_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic walk;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_walk;
    logic walk_done;
  } sts_t;

endpackage

>>> src/grd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grd_if
// Valid/ready channels of the graph reachability block.
// ----------------------------------------------------------------------------

// Request channel
interface grd_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [grd_pkg::VTX_W-1:0] first_vertex;
  logic [grd_pkg::VTX_W-1:0] second_vertex;

  modport source (output valid, opcode, first_vertex, second_vertex, input ready);
  modport sink   (input valid, opcode, first_vertex, second_vertex, output ready);
endinterface

// Result channel
interface grd_out_if;
  logic valid;
  logic ready;
  logic path_exists;
  logic status;

  modport source (output valid, path_exists, status, input ready);
  modport sink   (input valid, path_exists, status, output ready);
endinterface

// Configuration write channel
interface grd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [grd_pkg::CNT_W-1:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

>>> src/grd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grd_ctrl
// Sequencer: accepts a request, runs the operation or the walk, then hands
// the result to the output register.
// ----------------------------------------------------------------------------
module grd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  grd_pkg::sts_t sts,
  output grd_pkg::cmd_t cmd
);
  import grd_pkg::*;

  st_t  state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = sts.is_walk ? ST_WALK : ST_EMIT;
      ST_WALK: if (sts.walk_done) state_nxt = ST_EMIT;
      ST_EMIT: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_WALK: cmd.walk = 1'b1;
      ST_EMIT: cmd.load_out = slot_free;
      default: ;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/grd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grd_dpath
// Adjacency matrix, vertex count, visited and pending marks, the
// one-row-per-cycle walk step and the output register.
// ----------------------------------------------------------------------------
module grd_dpath #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  grd_pkg::cmd_t             cmd,
  output grd_pkg::sts_t             sts,
  input  logic [1:0]                in_opcode,
  input  logic [grd_pkg::VTX_W-1:0] in_first,
  input  logic [grd_pkg::VTX_W-1:0] in_second,
  input  logic                      cfg_we,
  input  logic [grd_pkg::CNT_W-1:0] cfg_count,
  output logic                      out_path_exists,
  output logic                      out_status
);
  import grd_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  op_t                     op_r;
  logic [VTX_W-1:0]        a_r;
  logic [VTX_W-1:0]        b_r;
  logic [CNT_W-1:0]        vc_r;
  logic [MAX_VERTICES-1:0] adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited_r;
  logic [MAX_VERTICES-1:0] pending_r;
  logic                    out_path_r;
  logic                    out_status_r;

  logic [VW-1:0]           a_idx, b_idx, cur;
  logic [MAX_VERTICES-1:0] mask, fresh, cur_bit, start_bit;
  logic                    a_bad, b_bad, bad;

  assign a_idx = VW'(a_r);
  assign b_idx = VW'(b_r);

  // Range check against min(vertex_count, MAX_VERTICES)
  assign a_bad = (int'(a_r) >= int'(vc_r)) || (int'(a_r) >= MAX_VERTICES);
  assign b_bad = (int'(b_r) >= int'(vc_r)) || (int'(b_r) >= MAX_VERTICES);
  assign bad   = (op_r != OP_CLEAR) && (a_bad || b_bad);

  // Active vertex mask
  always_comb begin
    for (int v = 0; v < MAX_VERTICES; v++) begin
      mask[v] = (int'(vc_r) > v);
    end
  end

  // Pick the highest pending vertex
  always_comb begin
    cur = '0;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      if (pending_r[v]) cur = VW'(v);
    end
  end

  always_comb begin
    cur_bit      = '0;
    cur_bit[cur] = 1'b1;
    start_bit        = '0;
    start_bit[a_idx] = 1'b1;
  end

  assign fresh = adj_r[cur] & mask & ~visited_r;

  // Status to controller
  assign sts.is_walk   = (op_r == OP_QUERY) && !bad;
  assign sts.walk_done = (pending_r == '0);

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= op_t'(in_opcode);
      a_r  <= in_first;
      b_r  <= in_second;
    end
  end

  // Vertex count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= CNT_RESET;
    end else if (cfg_we) begin
      vc_r <= cfg_count;
    end
  end

  // Adjacency matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_VERTICES; r++) adj_r[r] <= '0;
    end else if (cmd.exec) begin
      case (op_r)
        OP_CLEAR: begin
          for (int r = 0; r < MAX_VERTICES; r++) adj_r[r] <= '0;
        end
        OP_ADD_DIR: begin
          if (!bad) adj_r[a_idx][b_idx] <= 1'b1;
        end
        OP_ADD_UNDIR: begin
          if (!bad) begin
            adj_r[a_idx][b_idx] <= 1'b1;
            adj_r[b_idx][a_idx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Walk: seed with the start vertex, then expand one vertex per cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && sts.is_walk) begin
      visited_r <= start_bit;
      pending_r <= start_bit;
    end else if (cmd.walk && !sts.walk_done) begin
      visited_r <= visited_r | fresh;
      pending_r <= (pending_r & ~cur_bit) | fresh;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_path_r   <= sts.is_walk && visited_r[b_idx];
      out_status_r <= bad;
    end
  end

  assign out_path_exists = out_path_r;
  assign out_status      = out_status_r;

endmodule

>>> src/graph_reachability_dfs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_reachability_dfs
// Reachability over a directed graph kept as an adjacency bit matrix.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_req   | in  | valid / ready | opcode, first_vertex, second_vertex
//  out_rsp  | out | valid / ready | path_exists, status
//  cfg_wr   | in  | valid / ready | vertex_count (always ready)
//
//  Edge ops, clear and rejected requests pass through the EXEC and EMIT
//  states after accept; a query walks between them (WALK state), reading
//  one adjacency row per cycle, one row per vertex reached (at most
//  MAX_VERTICES), until no vertex is pending. EMIT loads the result into
//  the output register once that register is free or being read.
//  One request is in flight at a time; a result waits in the output register
//  while the next request is accepted and worked on.
//  Synchronous reset clears the graph and sets vertex_count to 16.
// ----------------------------------------------------------------------------
module graph_reachability_dfs #(
  parameter int MAX_VERTICES = 16
) (
  input  logic clk,
  input  logic rst_n,
  grd_in_if.sink    in_req,
  grd_out_if.source out_rsp,
  grd_cfg_if.sink   cfg_wr
);
  import grd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_wr.ready = 1'b1;

  // Sequencer
  grd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Graph storage and walk
  grd_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_req.opcode),
    .in_first        (in_req.first_vertex),
    .in_second       (in_req.second_vertex),
    .cfg_we          (cfg_wr.valid),
    .cfg_count       (cfg_wr.vertex_count),
    .out_path_exists (out_rsp.path_exists),
    .out_status      (out_rsp.status)
  );

endmodule

>>> src/grd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grd_checker
// Port-level checks of the graph reachability block, bound to the top level.
// ----------------------------------------------------------------------------
module grd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic path_exists,
  input logic status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(path_exists) && $stable(status))
    else $error("result changed while stalled");

  // A rejected request never reports a path
  a_err_no_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> !path_exists)
    else $error("path reported with error status");

  // One request at a time: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind graph_reachability_dfs grd_checker u_grd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .path_exists (out_rsp.path_exists),
  .status      (out_rsp.status)
);
